FILE: sv/mtf_pkg.sv
`default_nettype none
package mtf_pkg;

  // List capacity and derived widths
  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int ID_W  = 32;

  // Outcome of one scan step, from the compare unit to the sequencer
  typedef struct packed {
    logic append;  // slot is past the last valid entry: place carry here, grow list
    logic hit;     // slot holds the identifier: place carry here, stop
    logic drop;    // last slot of a full list, no match: evict its entry
  } scan_dec_t;

endpackage
`default_nettype wire

FILE: sv/move_to_front_list_top.sv
`default_nettype none
// Move-to-front list of up to DEPTH distinct 32-bit identifiers.
//
// Input channel (item_valid / item_stall): ident and end_of_list. Each
// identifier is moved to the front of the list, or inserted at the front if
// absent; on a full list the least recent entry is evicted, and dropped_any
// is flagged with the entries of the next emission.
// Output channel (entry_valid / entry_stall): after an item with end_of_list
// set, the list is sent most recent first, last_entry marks the final
// transaction, and the list and drop flag are then cleared.
//
// Timing: one compare per cycle walks the list in a RAM with one read and one
// write port. After its transaction an item holds the input stalled while the
// scan walks up to p, the match position or the current entry count (the last
// slot on a full list), so no new item is taken before that scan ends.
// Emission reads the first entry, then loads each entry and waits for it to
// be taken. When the receiver stalls, the current result transaction holds.
// Reset empties the list and clears the pending drop flag; RAM contents are
// not cleared, since only entries below the count are ever used.
module move_to_front_list_top (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            item_valid,
  output      logic                            item_stall,
  input  wire logic signed [mtf_pkg::ID_W-1:0] ident,
  input  wire logic                            end_of_list,
  output      logic                            entry_valid,
  input  wire logic                            entry_stall,
  output      logic signed [mtf_pkg::ID_W-1:0] entry_ident,
  output      logic                            last_entry,
  output      logic                            dropped_any
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_EMIT_WAIT
  } state_t;

  state_t                       state;
  logic [mtf_pkg::IDX_W-1:0]    idx;
  logic [mtf_pkg::IDX_W-1:0]    ek;
  logic [mtf_pkg::CNT_W-1:0]    count;
  logic                         overflow;
  logic                         eol;
  logic [mtf_pkg::ID_W-1:0]     key;
  logic [mtf_pkg::ID_W-1:0]     carry;

  logic                         ram_we;
  logic [mtf_pkg::IDX_W-1:0]    ram_waddr;
  logic [mtf_pkg::IDX_W-1:0]    ram_raddr;
  logic [mtf_pkg::ID_W-1:0]     ram_rdata;
  mtf_pkg::scan_dec_t           dec;
  logic                         in_xfer;
  logic                         out_xfer;
  logic                         ek_last;

  assign item_stall = (state != ST_IDLE);
  assign in_xfer    = item_valid && !item_stall;
  assign out_xfer   = entry_valid && !entry_stall;
  assign ek_last    = ((mtf_pkg::CNT_W'(ek) + mtf_pkg::CNT_W'(1)) == count);

  // Write the carried identifier at the scan slot
  assign ram_we    = (state == ST_SCAN);
  assign ram_waddr = idx;

  // Read address: lead the scan by one slot, follow the emit pointer
  always_comb begin
    unique case (state)
      ST_IDLE:      ram_raddr = '0;
      ST_SCAN:      ram_raddr = idx + mtf_pkg::IDX_W'(1);
      ST_EMIT_WAIT: ram_raddr = ek + mtf_pkg::IDX_W'(1);
      default:      ram_raddr = ek;
    endcase
  end

  mtf_ram #(
    .WIDTH (mtf_pkg::ID_W),
    .DEPTH (mtf_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (carry),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  mtf_cmp u_cmp (
    .idx   (idx),
    .count (count),
    .entry (ram_rdata),
    .key   (key),
    .dec   (dec)
  );

  // Sequencer: scan and shift, then emit the list
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      count       <= '0;
      overflow    <= 1'b0;
      entry_valid <= 1'b0;
      idx         <= '0;
      ek          <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            key   <= ident;
            carry <= ident;
            eol   <= end_of_list;
            idx   <= '0;
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (dec.append || dec.hit || dec.drop) begin
            if (dec.append) begin
              count <= count + mtf_pkg::CNT_W'(1);
            end
            if (dec.drop) begin
              overflow <= 1'b1;
            end
            ek    <= '0;
            state <= eol ? ST_EMIT_RD : ST_IDLE;
          end else begin
            // Push the displaced entry one slot back
            carry <= ram_rdata;
            idx   <= idx + mtf_pkg::IDX_W'(1);
          end
        end
        ST_EMIT_RD: begin
          state <= ST_EMIT_LD;
        end
        ST_EMIT_LD: begin
          entry_valid <= 1'b1;
          entry_ident <= ram_rdata;
          last_entry  <= ek_last;
          dropped_any <= overflow;
          state       <= ST_EMIT_WAIT;
        end
        ST_EMIT_WAIT: begin
          if (out_xfer) begin
            entry_valid <= 1'b0;
            if (ek_last) begin
              count    <= '0;
              overflow <= 1'b0;
              state    <= ST_IDLE;
            end else begin
              ek    <= ek + mtf_pkg::IDX_W'(1);
              state <= ST_EMIT_LD;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: sv/mtf_ram.sv
`default_nettype none
module mtf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: sv/mtf_cmp.sv
`default_nettype none
module mtf_cmp (
  input  wire logic [mtf_pkg::IDX_W-1:0] idx,
  input  wire logic [mtf_pkg::CNT_W-1:0] count,
  input  wire logic [mtf_pkg::ID_W-1:0]  entry,
  input  wire logic [mtf_pkg::ID_W-1:0]  key,
  output      mtf_pkg::scan_dec_t        dec
);

  logic at_end;
  logic match;
  logic at_last;

  // Classify the slot under the scan pointer
  assign at_end  = ({1'b0, idx} == count);
  assign match   = (entry == key);
  assign at_last = (idx == mtf_pkg::IDX_W'(mtf_pkg::DEPTH - 1));

  always_comb begin
    dec = '0;
    priority if (at_end) begin
      dec.append = 1'b1;
    end else if (match) begin
      dec.hit = 1'b1;
    end else if (at_last) begin
      dec.drop = 1'b1;
    end else begin
      // Keep scanning: no decision at this slot
      dec = '0;
    end
  end

endmodule
`default_nettype wire

FILE: sv/mtf_checker.sv
`default_nettype none
module mtf_checker (
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      item_valid,
  input wire logic                      item_stall,
  input wire logic                      entry_valid,
  input wire logic                      entry_stall,
  input wire logic [mtf_pkg::ID_W-1:0]  entry_ident,
  input wire logic                      last_entry
);

  // An accepted item keeps the block busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> item_stall)
    else $error("input not stalled after an accepted transaction");

  // No input is taken while results are pending
  a_stall_while_emit: assert property (@(posedge clk) disable iff (rst)
    entry_valid |-> item_stall)
    else $error("input open while a result is pending");

  // Emission continues until the last entry is taken
  a_emit_continues: assert property (@(posedge clk) disable iff (rst)
    entry_valid && !entry_stall && !last_entry |=> item_stall)
    else $error("block went idle before the last entry");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    entry_valid && entry_stall |=> entry_valid && $stable(entry_ident))
    else $error("stalled result transaction changed");

endmodule

bind move_to_front_list_top mtf_checker u_mtf_checker (
  .clk         (clk),
  .rst         (rst),
  .item_valid  (item_valid),
  .item_stall  (item_stall),
  .entry_valid (entry_valid),
  .entry_stall (entry_stall),
  .entry_ident (entry_ident),
  .last_entry  (last_entry)
);
`default_nettype wire

FILE: tb/sv/move_to_front_list_checker.sv
`timescale 1ns / 100ps
module move_to_front_list_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  input  logic                            item_stall,
  input  logic signed [mtf_pkg::ID_W-1:0] ident,
  input  logic                            end_of_list,
  input  logic                            entry_valid,
  input  logic                            entry_stall,
  input  logic signed [mtf_pkg::ID_W-1:0] entry_ident,
  input  logic                            last_entry,
  input  logic                            dropped_any,
  output int                              fail_count,
  output int                              pending,
  output int                              entries_checked
);

  typedef struct packed {
    logic signed [mtf_pkg::ID_W-1:0] ident;
    logic                            last;
    logic                            dropped;
  } list_entry_t;

  // Predicted list, most recent first
  logic [mtf_pkg::ID_W-1:0] recent [mtf_pkg::DEPTH];
  int                       recent_len;
  logic                     spilled;
  list_entry_t              expected_entries [$];

  initial begin
    fail_count      = 0;
    pending         = 0;
    entries_checked = 0;
    recent_len      = 0;
    spilled         = 1'b0;
  end

  task automatic report_mismatch(input string what, input logic [mtf_pkg::ID_W-1:0] got,
                                 input logic [mtf_pkg::ID_W-1:0] want);
    $display("%0t ns: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    fail_count = fail_count + 1;
  endtask

  // Move an identifier to the front, inserting it (and evicting the tail) if absent
  function automatic void move_to_front(input logic [mtf_pkg::ID_W-1:0] id);
    int pos;
    pos = recent_len;
    for (int i = 0; i < recent_len; i++) begin
      if (recent[i] == id) begin
        pos = i;
        break;
      end
    end
    if (pos >= recent_len) begin
      if (recent_len >= mtf_pkg::DEPTH) begin
        spilled = 1'b1;
        pos = mtf_pkg::DEPTH - 1;
      end else begin
        pos = recent_len;
        recent_len = recent_len + 1;
      end
    end
    for (int i = pos; i > 0; i--) recent[i] = recent[i - 1];
    recent[0] = id;
  endfunction

  // Queue the whole list for emission, then clear it
  function automatic void emit_list();
    list_entry_t e;
    for (int k = 0; k < recent_len; k++) begin
      e.ident   = recent[k];
      e.last    = (k + 1 == recent_len);
      e.dropped = spilled;
      expected_entries.insert(expected_entries.size(), e);
    end
    recent_len = 0;
    spilled    = 1'b0;
  endfunction

  always @(posedge clk) begin
    list_entry_t want;
    if (rst) begin
      recent_len = 0;
      spilled    = 1'b0;
      expected_entries.delete();
    end else begin
      // Compare each result transaction with the oldest prediction
      if (entry_valid && !entry_stall) begin
        entries_checked = entries_checked + 1;
        if (expected_entries.size() == 0) begin
          report_mismatch("unexpected entry_ident", entry_ident, '0);
        end else begin
          want = expected_entries.pop_front();
          if (entry_ident !== want.ident)
            report_mismatch("entry_ident", entry_ident, want.ident);
          if (last_entry !== want.last)
            report_mismatch("last_entry", mtf_pkg::ID_W'(last_entry),
                            mtf_pkg::ID_W'(want.last));
          if (dropped_any !== want.dropped)
            report_mismatch("dropped_any", mtf_pkg::ID_W'(dropped_any),
                            mtf_pkg::ID_W'(want.dropped));
        end
      end
      // Apply each accepted input transaction to the predicted list
      if (item_valid && !item_stall) begin
        move_to_front(ident);
        if (end_of_list) emit_list();
      end
    end
    pending = expected_entries.size();
  end

endmodule

FILE: tb/sv/move_to_front_list_top_tb.sv
`timescale 1ns / 100ps
module move_to_front_list_top_tb;

  localparam int RANDOM_ITEMS = 300;

  logic                            clk;
  logic                            rst;
  logic                            item_valid;
  logic                            item_stall;
  logic signed [mtf_pkg::ID_W-1:0] ident;
  logic                            end_of_list;
  logic                            entry_valid;
  logic                            entry_stall;
  logic signed [mtf_pkg::ID_W-1:0] entry_ident;
  logic                            last_entry;
  logic                            dropped_any;

  int fail_count;
  int pending;
  int entries_checked;
  int items_sent;
  int lists_sent;
  int stall_left;
  bit tx_quiet;
  bit rx_quiet;

  move_to_front_list_top dut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .ident       (ident),
    .end_of_list (end_of_list),
    .entry_valid (entry_valid),
    .entry_stall (entry_stall),
    .entry_ident (entry_ident),
    .last_entry  (last_entry),
    .dropped_any (dropped_any)
  );

  move_to_front_list_checker checker_i (
    .clk             (clk),
    .rst             (rst),
    .item_valid      (item_valid),
    .item_stall      (item_stall),
    .ident           (ident),
    .end_of_list     (end_of_list),
    .entry_valid     (entry_valid),
    .entry_stall     (entry_stall),
    .entry_ident     (entry_ident),
    .last_entry      (last_entry),
    .dropped_any     (dropped_any),
    .fail_count      (fail_count),
    .pending         (pending),
    .entries_checked (entries_checked)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Mostly short idle stretches, now and then a long one
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Receiver: stall at random, with quiet stretches
  initial begin
    entry_stall = 1'b0;
    stall_left  = 0;
    rx_quiet    = 1'b0;
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      entry_stall <= 1'b1;
      stall_left = stall_left - 1;
    end else begin
      entry_stall <= 1'b0;
      if ($urandom_range(0, 63) == 0) rx_quiet = !rx_quiet;
      stall_left = rx_quiet ? 0 : idle_len();
    end
  end

  // Send one input transaction after a random gap; hold it until accepted
  task automatic send_item(input logic [mtf_pkg::ID_W-1:0] id, input logic eol);
    int unsigned gap;
    gap = tx_quiet ? 0 : idle_len();
    if (gap > 0) begin
      @(negedge clk);
      item_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    item_valid  <= 1'b1;
    ident       <= id;
    end_of_list <= eol;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    items_sent = items_sent + 1;
    if (eol) lists_sent = lists_sent + 1;
  endtask

  // Hold off the sender until every predicted entry has come out
  task automatic drain_lists();
    @(negedge clk);
    item_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Random sequence: mostly identifiers drawn from a small pool, some noise
  task automatic send_sequence();
    logic [mtf_pkg::ID_W-1:0] pool [32];
    int unsigned pool_len;
    int unsigned seq_len;
    bit noise;
    noise = ($urandom_range(0, 9) < 2);
    pool_len = ($urandom_range(0, 5) == 0) ? $urandom_range(17, 32) : $urandom_range(1, 16);
    seq_len = noise ? $urandom_range(1, 5) :
              (($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 16));
    pool[0] = $urandom;
    for (int i = 1; i < 32; i++) begin
      // entries one bit apart from pool[0] exercise the full-width compare
      pool[i] = $urandom_range(0, 1) ? $urandom : pool[0] ^ (32'h1 << $urandom_range(0, 31));
    end
    for (int k = 0; k < seq_len; k++) begin
      if (noise)
        send_item($urandom, (k == seq_len - 1) || ($urandom_range(0, 3) == 0));
      else
        send_item(pool[$urandom_range(0, pool_len - 1)], k == seq_len - 1);
    end
  endtask

  initial begin
    rst         = 1'b1;
    item_valid  = 1'b0;
    ident       = '0;
    end_of_list = 1'b0;
    items_sent  = 0;
    lists_sent  = 0;
    tx_quiet    = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Single entry at the most negative identifier
    send_item(32'h8000_0000, 1'b1);
    // Extremes, a hit in the middle, a hit at the front, a hit at the tail
    send_item(32'h7fff_ffff, 1'b0);
    send_item(32'h0000_0000, 1'b0);
    send_item(32'hffff_ffff, 1'b0);
    send_item(32'h0000_0000, 1'b0);
    send_item(32'h0000_0000, 1'b0);
    send_item(32'h7fff_ffff, 1'b1);
    // Fill past capacity so the tail is evicted
    for (int k = 0; k <= mtf_pkg::DEPTH; k++)
      send_item(32'd1000 + k, k == mtf_pkg::DEPTH);
    drain_lists();

    // Random sequences with random idling and occasional full drains
    while (items_sent < RANDOM_ITEMS + 24) begin
      tx_quiet = ($urandom_range(0, 4) == 0);
      send_sequence();
      if ($urandom_range(0, 5) == 0) drain_lists();
    end
    tx_quiet = 1'b0;
    @(negedge clk);
    item_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    $display("sent %0d identifiers in %0d lists, checked %0d list entries",
             items_sent, lists_sent, entries_checked);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("timeout with %0d entries still expected", pending);
    $display("status: fail");
    $finish;
  end

endmodule

FILE: move_to_front_list_top.f
sv/mtf_pkg.sv
sv/mtf_ram.sv
sv/mtf_cmp.sv
sv/move_to_front_list_top.sv
sv/mtf_checker.sv
tb/sv/move_to_front_list_checker.sv
tb/sv/move_to_front_list_top_tb.sv
